[rtl/rcfv_pkg.sv]
// shared types, constants and the crc step function for the channel frame validator
// no dependencies; every other file in rtl but rcfv_ram takes it in
package rcfv_pkg;

   // frame geometry
   localparam int PAYLOAD_BYTES = 24;
   localparam int FRAME_BYTES   = PAYLOAD_BYTES + 4;
   localparam int CRC_SPAN      = PAYLOAD_BYTES + 2;
   localparam int CHANNELS      = PAYLOAD_BYTES / 2;

   // widths
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 4;
   localparam int VALUE_W  = 17;
   localparam int CRC_W    = 16;
   localparam int ADDR_W   = $clog2(FRAME_BYTES);
   localparam int CNT_W    = $clog2(FRAME_BYTES + 1);
   localparam int SUM_W    = CNT_W + 1;
   localparam int KIDX_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   // crc-16/modbus constants
   localparam logic [CRC_W-1:0]  CRC_INIT      = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY      = 16'hA001;
   localparam logic [BYTE_W-1:0] SYNC_MASK_RST = 8'hA0;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RD_LO,
      ST_RD_HI,
      ST_LOAD
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic wr;         // store the accepted byte in the window
      logic scan_init;  // restart the read counter, crc and header flags
      logic scan;       // window read that feeds the checker
      logic emit_init;  // point the read counter at the first payload byte
      logic rd;         // issue a window read and step the counter
      logic latch_lo;   // keep the low payload byte of a channel
      logic load;       // load the result register
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic fills;      // window is full once the next byte is stored
      logic scan_done;  // last window byte has been checked
      logic frame_ok;   // all frame checks passed (valid with scan_done)
      logic out_free;   // result register can take a new transaction
      logic last_chan;  // current channel is the last of the frame
   } dp_stat_type;

   // one byte through the reflected crc, bit at a time
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int b = 0; b < BYTE_W; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // circular window address, sum stays below twice the window size
   function automatic logic [ADDR_W-1:0] wrap_addr(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] s;
      if (sum >= SUM_W'(FRAME_BYTES)) begin
         s = sum - SUM_W'(FRAME_BYTES);
      end else begin
         s = sum;
      end
      return s[ADDR_W-1:0];
   endfunction

endpackage

[rtl/rcfv_if.sv]
// valid/ready channel interfaces for received bytes and channel results
// depends on rcfv_pkg
interface rcfv_req_if;
   import rcfv_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcfv_rsp_if;
   import rcfv_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] channel_index;
   logic [VALUE_W-1:0] channel_value;
   logic               last_channel;

   modport source (output valid, output channel_index, output channel_value,
                   output last_channel, input ready);
   modport sink   (input valid, input channel_index, input channel_value,
                   input last_channel, output ready);
endinterface

[rtl/rcfv_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
module rcfv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 28
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rcfv_ctrl.sv]
// controller state machine: window update, frame check scan, channel output
// depends on rcfv_pkg
module rcfv_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rcfv_pkg::dp_stat_type stat,
   output rcfv_pkg::dp_cmd_type  cmd
);
   import rcfv_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && stat.fills) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = stat.frame_ok ? ST_RD_LO : ST_IDLE;
            end
         end
         ST_RD_LO: begin
            state_in = ST_RD_HI;
         end
         ST_RD_HI: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (stat.out_free) begin
               state_in = stat.last_chan ? ST_IDLE : ST_RD_LO;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.wr        = req_valid;
            cmd.scan_init = req_valid && stat.fills;
         end
         ST_SCAN: begin
            cmd.rd        = 1'b1;
            cmd.scan      = 1'b1;
            cmd.emit_init = stat.scan_done && stat.frame_ok;
         end
         ST_RD_LO: begin
            cmd.rd = 1'b1;
         end
         ST_RD_HI: begin
            cmd.rd       = 1'b1;
            cmd.latch_lo = 1'b1;
         end
         ST_LOAD: begin
            cmd.load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[rtl/rcfv_dp.sv]
// datapath: circular byte window, header and crc checks, channel result register
// depends on rcfv_pkg and rcfv_ram
module rcfv_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  rcfv_pkg::dp_cmd_type          cmd,
   output rcfv_pkg::dp_stat_type         stat,
   input  logic [rcfv_pkg::BYTE_W-1:0]   rx_byte,
   input  logic                          csr_wr_en,
   input  logic [rcfv_pkg::BYTE_W-1:0]   csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rcfv_pkg::INDEX_W-1:0]  channel_index,
   output logic [rcfv_pkg::VALUE_W-1:0]  channel_value,
   output logic                          last_channel
);
   import rcfv_pkg::*;

   // window bookkeeping
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // check pipeline
   logic              rv_ff;
   logic [CNT_W-1:0]  rv_idx_ff;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic              ok_ff, ok_in;
   logic [BYTE_W-1:0] lo_ff, lo_in;
   logic [BYTE_W-1:0] sync_mask_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] index_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               last_ff;

   // ram ports
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;

   logic [KIDX_W-1:0] chan_k;

   rcfv_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FRAME_BYTES)
   ) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // channel number from the read counter, which sits past the high byte
   assign chan_k = (KIDX_W'(cnt_ff) - KIDX_W'(4)) >> 1;

   // window write and fill tracking
   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      wr_en   = cmd.wr;
      wr_addr = head_ff;
      if (cmd.wr) begin
         if (fill_ff < CNT_W'(FRAME_BYTES)) begin
            wr_addr = wrap_addr(SUM_W'(head_ff) + SUM_W'(fill_ff));
            fill_in = fill_ff + CNT_W'(1);
         end else begin
            head_in = wrap_addr(SUM_W'(head_ff) + SUM_W'(1));
         end
      end
      if (cmd.load && stat.last_chan) begin
         fill_in = '0;
      end
   end

   // window reads, oldest byte first
   always_comb begin
      rd_en   = cmd.rd;
      rd_addr = wrap_addr(SUM_W'(head_ff) + SUM_W'(cnt_ff));
      cnt_in  = cnt_ff;
      if (cmd.scan_init) begin
         cnt_in = '0;
      end else if (cmd.emit_init) begin
         cnt_in = CNT_W'(2);
      end else if (cmd.rd) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   // header checks and crc over the returned bytes
   always_comb begin
      crc_in = crc_ff;
      ok_in  = ok_ff;
      lo_in  = lo_ff;
      if (cmd.scan_init) begin
         crc_in = CRC_INIT;
         ok_in  = 1'b1;
      end else if (rv_ff) begin
         if (rv_idx_ff < CNT_W'(CRC_SPAN)) begin
            crc_in = crc_byte(crc_ff, rd_data);
         end
         if (rv_idx_ff == '0) begin
            ok_in = (rd_data & sync_mask_ff) == sync_mask_ff;
         end
         if (rv_idx_ff == CNT_W'(1)) begin
            ok_in = ok_ff && (rd_data == BYTE_W'(PAYLOAD_BYTES));
         end
         if (rv_idx_ff == CNT_W'(CRC_SPAN)) begin
            lo_in = rd_data;
         end
      end
      if (cmd.latch_lo) begin
         lo_in = rd_data;
      end
   end

   // status
   always_comb begin
      stat.fills     = fill_ff >= CNT_W'(FRAME_BYTES - 1);
      stat.scan_done = rv_ff && (rv_idx_ff == CNT_W'(FRAME_BYTES - 1));
      stat.frame_ok  = ok_ff && (crc_ff == {rd_data, lo_ff});
      stat.out_free  = !rsp_valid_ff || rsp_ready;
      stat.last_chan = chan_k == KIDX_W'(CHANNELS - 1);
   end

   // result valid flag
   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sync_mask_ff <= SYNC_MASK_RST;
      end else begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rv_ff        <= cmd.scan;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            sync_mask_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      rv_idx_ff <= cnt_ff;
      crc_ff    <= crc_in;
      ok_ff     <= ok_in;
      lo_ff     <= lo_in;
      if (cmd.load) begin
         index_ff <= chan_k[INDEX_W-1:0];
         value_ff <= {rd_data, lo_ff, 1'b0};
         last_ff  <= stat.last_chan;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign channel_index = index_ff;
   assign channel_value = value_ff;
   assign last_channel  = last_ff;

endmodule

[rtl/rc_channel_frame_validator_top.sv]
// top level of the radio channel frame validator
// depends on rcfv_pkg, rcfv_if, rcfv_ctrl, rcfv_dp and rcfv_ram
//
//   channel   dir   handshake            payload
//   req_port  in    valid/ready          rx_byte[7:0]
//   rsp_port  out   valid/ready          channel_index[3:0] channel_value[16:0] last_channel
//   csr       in    csr_wr_en, no wait   csr_wr_data[7:0] = sync_mask
//
// a byte that leaves the window short of a full frame is only written into the window
// each byte that leaves the window full starts a scan: one ram read per window byte through
// a byte-at-a-time crc, plus ram read latency
// a valid frame then emits each channel via rd_lo, rd_hi and load, plus any output stall time
// the result register lets the next byte be accepted while a result waits
// synchronous active-high reset; window contents are not cleared, only the head and fill count
module rc_channel_frame_validator_top (
   input  logic                         clock,
   input  logic                         reset,
   rcfv_req_if.sink                     req_port,
   rcfv_rsp_if.source                   rsp_port,
   input  logic                         csr_wr_en,
   input  logic [rcfv_pkg::BYTE_W-1:0]  csr_wr_data
);
   import rcfv_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // controller
   rcfv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   rcfv_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .rx_byte       (req_port.rx_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_port.valid),
      .rsp_ready     (rsp_port.ready),
      .channel_index (rsp_port.channel_index),
      .channel_value (rsp_port.channel_value),
      .last_channel  (rsp_port.last_channel)
   );

endmodule
